### rtl/cswd_pkg.sv
// ----------------------------------------------------------------------------
// Capture watchdog package
// Shared widths, codes, payload and configuration types for the capture
// stall and frozen-readback watchdog.
// ----------------------------------------------------------------------------
package cswd_pkg;

	// Widths of all time values and of the successful-restart counters.
	localparam int TIME_BITS  = 48;
	localparam int COUNT_BITS = 32;

	// Frozen streak counter and configuration index widths.
	localparam int STREAK_BITS = 8;
	localparam int INDEX_BITS  = 3;

	typedef logic [TIME_BITS-1:0]   time_t;
	typedef logic [COUNT_BITS-1:0]  cnt_t;
	typedef logic [STREAK_BITS-1:0] streak_t;
	typedef logic [INDEX_BITS-1:0]  cfg_index_t;

	localparam time_t   TIME_ZERO  = '0;
	localparam cnt_t    CNT_MAX    = '1;
	localparam streak_t STREAK_MAX = '1;

	// Register reset values.
	localparam time_t   RST_STALL_LIMIT  = time_t'(2000000);
	localparam time_t   RST_COOLDOWN     = time_t'(5000000);
	localparam time_t   RST_SLOW_WARN    = time_t'(250000);
	localparam time_t   RST_FROZEN_AGE   = time_t'(2000000);
	localparam streak_t RST_STREAK_LIMIT = streak_t'(2);
	localparam time_t   RST_ESC_WINDOW   = time_t'(60000000);
	localparam time_t   RST_SLOW_WINDOW  = time_t'(1000000);

	// Configuration register indexes.
	typedef enum logic [INDEX_BITS-1:0] {
		REG_STALL_LIMIT  = 3'd0,
		REG_COOLDOWN     = 3'd1,
		REG_SLOW_WARN    = 3'd2,
		REG_FROZEN_AGE   = 3'd3,
		REG_STREAK_LIMIT = 3'd4,
		REG_ESC_WINDOW   = 3'd5,
		REG_SLOW_WINDOW  = 3'd6
	} cfg_reg_t;

	// Action codes reported with every result word.
	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_STALL    = 2'd1,
		ACT_FROZEN   = 2'd2,
		ACT_ESCALATE = 2'd3
	} action_t;

	// One poll tick.
	typedef struct packed {
		time_t now_us;
		logic  capture_enabled;
		logic  backend_clocked;
		time_t last_callback_us;
		time_t session_start_us;
		time_t oldest_pending_us;
		logic  restart_ok;
	} poll_t;

	// One result word.
	typedef struct packed {
		action_t action;
		logic    slow_warn;
		time_t   slow_peak_us;
		cnt_t    restarts_done;
		cnt_t    frozen_restarts_done;
	} result_t;

	// Current register settings.
	typedef struct packed {
		time_t   stall_limit_us;
		time_t   cooldown_us;
		time_t   slow_warn_us;
		time_t   frozen_age_us;
		streak_t streak_limit;
		time_t   escalation_window_us;
		time_t   slow_window_us;
	} cfg_t;

	// True when now has reached base + span, with no overflow in the sum.
	function automatic logic elapsed(time_t now, time_t base, time_t span);
		return (now >= base) && ((now - base) >= span);
	endfunction

	// Saturating increment of a restart counter.
	function automatic cnt_t sat_inc(cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

endpackage

### rtl/cswd_cfg.sv
// ----------------------------------------------------------------------------
// Capture watchdog configuration registers
// Holds the seven settings and takes one write per cycle. Writes to an
// index beyond the list are accepted and dropped.
// ----------------------------------------------------------------------------
module cswd_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cswd_pkg::cfg_index_t  cfg_index,
	input  cswd_pkg::time_t       cfg_data,
	output cswd_pkg::cfg_t        cfg
);

	cswd_pkg::cfg_t cfg_q;

	// The register file never pushes back.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_limit_us       <= cswd_pkg::RST_STALL_LIMIT;
			cfg_q.cooldown_us          <= cswd_pkg::RST_COOLDOWN;
			cfg_q.slow_warn_us         <= cswd_pkg::RST_SLOW_WARN;
			cfg_q.frozen_age_us        <= cswd_pkg::RST_FROZEN_AGE;
			cfg_q.streak_limit         <= cswd_pkg::RST_STREAK_LIMIT;
			cfg_q.escalation_window_us <= cswd_pkg::RST_ESC_WINDOW;
			cfg_q.slow_window_us       <= cswd_pkg::RST_SLOW_WINDOW;
		end else if (cfg_valid) begin
			case (cfg_index)
				cswd_pkg::REG_STALL_LIMIT:  cfg_q.stall_limit_us <= cfg_data;
				cswd_pkg::REG_COOLDOWN:     cfg_q.cooldown_us <= cfg_data;
				cswd_pkg::REG_SLOW_WARN:    cfg_q.slow_warn_us <= cfg_data;
				cswd_pkg::REG_FROZEN_AGE:   cfg_q.frozen_age_us <= cfg_data;
				cswd_pkg::REG_STREAK_LIMIT: begin
					cfg_q.streak_limit <= cfg_data[cswd_pkg::STREAK_BITS-1:0];
				end
				cswd_pkg::REG_ESC_WINDOW:   cfg_q.escalation_window_us <= cfg_data;
				cswd_pkg::REG_SLOW_WINDOW:  cfg_q.slow_window_us <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### rtl/cswd_core.sv
// ----------------------------------------------------------------------------
// Capture watchdog decision core
// Holds the watchdog state and computes one result word per poll tick from
// the registered tick. State moves only when the tick is handed on.
// ----------------------------------------------------------------------------
module cswd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  cswd_pkg::poll_t    item,
	input  cswd_pkg::cfg_t     cfg,
	output cswd_pkg::result_t  res
);

	cswd_pkg::time_t   last_restart_q, last_frozen_q, win_start_q, win_peak_q;
	cswd_pkg::streak_t streak_q;
	cswd_pkg::cnt_t    restarts_q, frozen_restarts_q;

	cswd_pkg::time_t   last_restart_d, last_frozen_d, win_start_d, win_peak_d;
	cswd_pkg::streak_t streak_d;
	cswd_pkg::cnt_t    restarts_d, frozen_restarts_d;

	cswd_pkg::time_t   base, peak_upd, win_base;
	cswd_pkg::streak_t streak_upd;
	logic              cool_done, win_close, refroze, frozen_act;

	// Next-state and result logic for one tick.
	always_comb begin
		last_restart_d    = last_restart_q;
		last_frozen_d     = last_frozen_q;
		win_start_d       = win_start_q;
		win_peak_d        = win_peak_q;
		streak_d          = streak_q;
		restarts_d        = restarts_q;
		frozen_restarts_d = frozen_restarts_q;

		res.action       = cswd_pkg::ACT_NONE;
		res.slow_warn    = 1'b0;
		res.slow_peak_us = cswd_pkg::TIME_ZERO;

		cool_done = (last_restart_q == cswd_pkg::TIME_ZERO) ||
			cswd_pkg::elapsed(item.now_us, last_restart_q, cfg.cooldown_us);

		// Stall rule: callback time, or session start when no callback yet.
		base = (item.last_callback_us != cswd_pkg::TIME_ZERO) ?
			item.last_callback_us : item.session_start_us;

		// Slow readback window: update the peak, then see if the window closes.
		peak_upd = ((item.oldest_pending_us >= cfg.slow_warn_us) &&
			(item.oldest_pending_us > win_peak_q)) ? item.oldest_pending_us : win_peak_q;
		win_base = (win_start_q == cswd_pkg::TIME_ZERO) ? item.now_us : win_start_q;
		win_close = (item.now_us < win_base) ||
			((item.now_us - win_base) >= cfg.slow_window_us);

		// Frozen streak, saturating at its maximum.
		if (item.oldest_pending_us >= cfg.frozen_age_us) begin
			streak_upd = (streak_q == cswd_pkg::STREAK_MAX) ?
				streak_q : streak_q + cswd_pkg::streak_t'(1);
		end else begin
			streak_upd = '0;
		end
		frozen_act = (streak_upd >= cfg.streak_limit) && cool_done;
		refroze = (last_frozen_q != cswd_pkg::TIME_ZERO) &&
			!cswd_pkg::elapsed(item.now_us, last_frozen_q, cfg.escalation_window_us);

		if (item.capture_enabled && item.backend_clocked) begin
			if ((base != cswd_pkg::TIME_ZERO) &&
				cswd_pkg::elapsed(item.now_us, base, cfg.stall_limit_us) && cool_done) begin
				last_restart_d = item.now_us;
				res.action     = cswd_pkg::ACT_STALL;
				if (item.restart_ok) begin
					restarts_d = cswd_pkg::sat_inc(restarts_q);
				end
			end
		end else if (item.capture_enabled) begin
			if (win_close) begin
				if (peak_upd >= cfg.slow_warn_us) begin
					res.slow_warn    = 1'b1;
					res.slow_peak_us = peak_upd;
				end
				win_start_d = item.now_us;
				win_peak_d  = cswd_pkg::TIME_ZERO;
			end else begin
				win_start_d = win_base;
				win_peak_d  = peak_upd;
			end

			streak_d = streak_upd;
			if (frozen_act) begin
				streak_d      = '0;
				last_frozen_d = item.now_us;
				if (refroze) begin
					res.action = cswd_pkg::ACT_ESCALATE;
				end else begin
					last_restart_d = item.now_us;
					res.action     = cswd_pkg::ACT_FROZEN;
					if (item.restart_ok) begin
						restarts_d        = cswd_pkg::sat_inc(restarts_q);
						frozen_restarts_d = cswd_pkg::sat_inc(frozen_restarts_q);
					end
				end
			end
		end

		// Counters are reported after this tick's update.
		res.restarts_done        = restarts_d;
		res.frozen_restarts_done = frozen_restarts_d;
	end

	// Watchdog state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_restart_q    <= '0;
			last_frozen_q     <= '0;
			win_start_q       <= '0;
			win_peak_q        <= '0;
			streak_q          <= '0;
			restarts_q        <= '0;
			frozen_restarts_q <= '0;
		end else if (step) begin
			last_restart_q    <= last_restart_d;
			last_frozen_q     <= last_frozen_d;
			win_start_q       <= win_start_d;
			win_peak_q        <= win_peak_d;
			streak_q          <= streak_d;
			restarts_q        <= restarts_d;
			frozen_restarts_q <= frozen_restarts_d;
		end
	end

endmodule

### rtl/capture_stall_frozen_watchdog.sv
// ----------------------------------------------------------------------------
// Capture stall and frozen-readback watchdog
// Top level: input register, decision core, result register, configuration.
// ----------------------------------------------------------------------------
// The block takes one poll tick per clock cycle while the poll channel is not
// stalled and returns exactly one result word for each tick. The tick is
// captured in an input register, the decision core works on it and on the
// watchdog state combinationally, and the word is written into a result
// register when the tick is handed on. The word is offered from the result
// register and held there until the receiver takes it. The core updates its
// state as each tick is handed on, which lets each tick see the state left by
// the one before it. The poll channel stalls only while the result register is
// full and held by the receiver. Configuration writes are taken in every cycle
// and should be issued only while no tick is in flight.
module capture_stall_frozen_watchdog (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  poll_valid,
	output logic                  poll_stall,
	input  cswd_pkg::poll_t       poll,
	output logic                  result_valid,
	input  logic                  result_stall,
	output cswd_pkg::result_t     result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cswd_pkg::cfg_index_t  cfg_index,
	input  cswd_pkg::time_t       cfg_data
);

	cswd_pkg::cfg_t    cfg;
	cswd_pkg::poll_t   item_s1;
	cswd_pkg::result_t res_d, result_q;
	logic              valid_s1, result_valid_q, advance, step, accept;

	// The tick moves on when the result register is empty or being drained.
	assign advance    = !result_valid_q || !result_stall;
	assign step       = valid_s1 && advance;
	assign poll_stall = valid_s1 && !advance;
	assign accept     = poll_valid && !poll_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	cswd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cswd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= poll;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= res_d;
		end
	end

	// A stalled poll channel always has a tick waiting in the input register.
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		poll_stall |-> valid_s1)
		else $error("poll stall raised with an empty input register");

	// Restart counters never move backwards from one result word to the next.
	a_counter_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result_valid_q) |=>
		(result_q.restarts_done >= $past(result_q.restarts_done)) &&
		(result_q.frozen_restarts_done >= $past(result_q.frozen_restarts_done)))
		else $error("restart counter decreased");

	// Frozen restarts are a subset of all restarts.
	a_frozen_subset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.frozen_restarts_done <= result_q.restarts_done))
		else $error("frozen restart count exceeds total restart count");

	// The slow warning comes only from the unclocked-backend path, never with a stall restart.
	a_warn_path: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.slow_warn) |-> (result_q.action != cswd_pkg::ACT_STALL))
		else $error("slow warning reported together with a stall restart");

endmodule
